[rtl/mwf_pkg.sv]
// Shared types, constants and helpers of the median window filter.
// No dependencies; mwf_rank, median_window_filter and the testbench import this package.
`default_nettype none
package mwf_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_RADIUS   = 3;
  localparam int SIDE_MAX     = 2 * MAX_RADIUS + 1;
  localparam int WIN_MAX      = SIDE_MAX * SIDE_MAX;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int STORE_DEPTH  = SIDE_MAX * MAX_WIDTH;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int IDX_W        = $clog2(WIN_MAX);
  localparam int PROD_W       = ROW_W + COL_W + 1;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  localparam logic OP_PIXEL = 1'b0;

  typedef struct packed {
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_req_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } out_req_t;

  // Reduces row*width + column modulo the store depth (seven rows of 1024).
  // Bits above the row offset are reduced modulo 7 by folding octal digits.
  function automatic logic [ADDR_W-1:0] store_index(input logic [PROD_W-1:0] s);
    logic [PROD_W-11:0] hi;
    logic [4:0]         sum1;
    logic [3:0]         sum2;
    logic [2:0]         m;
    hi   = s[PROD_W-1:10];
    sum1 = 5'({2'b00, hi[2:0]}) + 5'({2'b00, hi[5:3]}) + 5'({2'b00, hi[8:6]})
         + 5'({2'b00, hi[11:9]}) + 5'({3'b000, hi[12]});
    sum2 = 4'({2'b00, sum1[4:3]}) + 4'({1'b0, sum1[2:0]});
    m    = (sum2 >= 4'd7) ? 3'(sum2 - 4'd7) : sum2[2:0];
    return {m, s[9:0]};
  endfunction

endpackage
`default_nettype wire

[rtl/mwf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mwf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 7168
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/mwf_rank.sv]
// Running rank selection: three rows of insertion cells, one per channel.
// Depends on mwf_pkg for window size and index width.
`default_nettype none
module mwf_rank
  import mwf_pkg::*;
(
  input  wire              clk_i,
  input  wire              clear_i,
  input  wire              insert_i,
  input  wire  [23:0]      pixel_i,
  input  wire  [IDX_W-1:0] med_idx_i,
  output logic [23:0]      median_o
);

  logic [7:0] cell_q [3][WIN_MAX];

  // Cells start at the maximum value so that the first n cells hold the
  // sorted samples after n insertions.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < WIN_MAX; k++) begin
        if (clear_i) begin
          cell_q[c][k] <= 8'hFF;
        end else if (insert_i) begin
          if (pixel_i[8*(2-c) +: 8] < cell_q[c][k]) begin
            if (k == 0) begin
              cell_q[c][k] <= pixel_i[8*(2-c) +: 8];
            end else if (pixel_i[8*(2-c) +: 8] >= cell_q[c][k-1]) begin
              cell_q[c][k] <= pixel_i[8*(2-c) +: 8];
            end else begin
              cell_q[c][k] <= cell_q[c][k-1];
            end
          end
        end
      end
    end
  end

  assign median_o = {cell_q[0][med_idx_i], cell_q[1][med_idx_i], cell_q[2][med_idx_i]};

endmodule
`default_nettype wire

[rtl/median_window_filter.sv]
// Streaming 2-D per-channel median filter over RGB pixels; needs mwf_pkg, mwf_ram, mwf_rank.
// A pixel request is written to the line store (S_WMUL, S_WR) and then checked; when a result
// is due, its window is gathered and ranked; a drain tick skips the write states. The single
// line-store read port, one window pixel per cycle, paces the gather, and a finished
// result waits while the output register is still held by a stall. Reset clears all
// positions and the frame flag and loads the register defaults; the line store is not cleared.
`default_nettype none
module median_window_filter
  import mwf_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cfg_we_i,
  input  wire  [1:0]      cfg_idx_i,
  input  wire  [12:0]     cfg_wdata_i,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  wire  in_req_t   in_req_i,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output out_req_t        out_req_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WMUL   = 3'd1;
  localparam logic [2:0] S_WR     = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_GATHER = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [10:0] width_reg_q;
  logic [12:0] height_reg_q;
  logic [1:0]  radius_reg_q;

  logic [COL_W-1:0] in_col_q, out_col_q;
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic             frame_rcv_q;
  logic [23:0]      pix_q;

  // Shared address unit: one multiply per cycle, reduced in the next.
  logic [PROD_W-1:0] prod_q;
  logic [COL_W-1:0]  col_q;
  logic [ADDR_W-1:0] addr;

  logic [2:0] dx_q, dy_q;
  logic       issue_done_q;
  logic       v1_q, v2_q;

  logic       out_valid_q;
  out_req_t   out_q;

  // Effective registers: out-of-range values saturate.
  logic [10:0] w;
  logic [12:0] h;
  logic [1:0]  rad;
  logic [2:0]  side_m1;
  logic [IDX_W-1:0] med_idx;

  always_comb begin
    if (width_reg_q == 11'd0) w = 11'd1;
    else if (width_reg_q > 11'(MAX_WIDTH)) w = 11'(MAX_WIDTH);
    else w = width_reg_q;
    if (height_reg_q == 13'd0) h = 13'd1;
    else if (height_reg_q > 13'(HEIGHT_LIMIT)) h = 13'(HEIGHT_LIMIT);
    else h = height_reg_q;
    rad = (radius_reg_q == 2'd0) ? 2'd1 : radius_reg_q;
    side_m1 = {rad, 1'b0};
    case (rad)
      2'd1:    med_idx = IDX_W'(4);
      2'd2:    med_idx = IDX_W'(12);
      default: med_idx = IDX_W'(24);
    endcase
  end

  // Readiness of the next output: the whole frame has been received, or the
  // bottom-right pixel of its clamped window has been written already.
  logic [12:0] ny;
  logic [10:0] nx;
  logic        ready;
  always_comb begin
    ny = 13'({1'b0, out_row_q}) + 13'(rad);
    if (ny > h - 13'd1) ny = h - 13'd1;
    nx = 11'({1'b0, out_col_q}) + 11'(rad);
    if (nx > w - 11'd1) nx = w - 11'd1;
    ready = frame_rcv_q || (13'(in_row_q) > ny)
         || ((13'(in_row_q) == ny) && (11'(in_col_q) > nx));
  end

  // Window coordinates of the current gather step, clamped to the frame.
  logic signed [13:0] yy_s;
  logic signed [11:0] xx_s;
  logic [ROW_W-1:0]   yy;
  logic [COL_W-1:0]   xx;
  always_comb begin
    yy_s = $signed({2'b00, out_row_q}) + $signed({11'b0, dy_q}) - $signed({12'b0, rad});
    xx_s = $signed({2'b00, out_col_q}) + $signed({9'b0, dx_q}) - $signed({10'b0, rad});
    if (yy_s < 14'sd0) yy = '0;
    else if (yy_s > $signed({1'b0, h - 13'd1})) yy = ROW_W'(h - 13'd1);
    else yy = yy_s[ROW_W-1:0];
    if (xx_s < 12'sd0) xx = '0;
    else if (xx_s > $signed({1'b0, w - 11'd1})) xx = COL_W'(w - 11'd1);
    else xx = xx_s[COL_W-1:0];
  end

  assign addr = store_index(prod_q + PROD_W'(col_q));

  logic        ram_we;
  logic [23:0] ram_rdata;
  logic [23:0] median;
  logic        rank_clear;
  logic        last;

  assign ram_we     = (state_q == S_WR);
  assign rank_clear = (state_q == S_CHK);
  assign last       = (13'({1'b0, out_row_q}) + 13'd1 >= h)
                   && (11'({1'b0, out_col_q}) + 11'd1 >= w);

  mwf_ram #(
    .WIDTH(24),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr),
    .wdata_i(pix_q),
    .raddr_i(addr),
    .rdata_o(ram_rdata)
  );

  mwf_rank u_rank (
    .clk_i    (clk_i),
    .clear_i  (rank_clear),
    .insert_i (v2_q),
    .pixel_i  (ram_rdata),
    .med_idx_i(med_idx),
    .median_o (median)
  );

  // A new request is taken only by the idle sequencer; the output register
  // decouples it from a stalled consumer.
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.operation == OP_PIXEL && !frame_rcv_q) state_d = S_WMUL;
          else state_d = S_CHK;
        end
      end
      S_WMUL: state_d = S_WR;
      S_WR:   state_d = S_CHK;
      S_CHK:  state_d = ready ? S_GATHER : S_IDLE;
      S_GATHER: begin
        if (issue_done_q && !v1_q && !v2_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      pix_q <= {in_req_i.red_in, in_req_i.green_in, in_req_i.blue_in};
    end
    if (state_q == S_WMUL) begin
      prod_q <= PROD_W'(in_row_q) * PROD_W'(w);
      col_q  <= in_col_q;
    end else if (state_q == S_GATHER) begin
      prod_q <= PROD_W'(yy) * PROD_W'(w);
      col_q  <= xx;
    end
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q.red_out    <= median[23:16];
      out_q.green_out  <= median[15:8];
      out_q.blue_out   <= median[7:0];
      out_q.frame_last <= last;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      width_reg_q  <= 11'(MAX_WIDTH);
      height_reg_q <= 13'd768;
      radius_reg_q <= 2'd1;
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      frame_rcv_q  <= 1'b0;
      dx_q         <= '0;
      dy_q         <= '0;
      issue_done_q <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_reg_q  <= cfg_wdata_i[10:0];
          CFG_HEIGHT: height_reg_q <= cfg_wdata_i;
          CFG_RADIUS: radius_reg_q <= cfg_wdata_i[1:0];
          default: ;
        endcase
      end

      // Input position advances once the pixel is in the line store.
      if (state_q == S_WR) begin
        if (11'({1'b0, in_col_q}) + 11'd1 >= w) begin
          in_col_q <= '0;
          if (13'({1'b0, in_row_q}) + 13'd1 >= h) begin
            in_row_q    <= '0;
            frame_rcv_q <= 1'b1;
          end else begin
            in_row_q <= in_row_q + ROW_W'(1);
          end
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
      end

      // Gather sequencer: issue one window read per cycle, row by row.
      v1_q <= (state_q == S_GATHER) && !issue_done_q;
      v2_q <= v1_q;
      if (state_q == S_CHK) begin
        dx_q         <= '0;
        dy_q         <= '0;
        issue_done_q <= 1'b0;
      end else if (state_q == S_GATHER && !issue_done_q) begin
        if (dx_q == side_m1) begin
          dx_q <= '0;
          if (dy_q == side_m1) issue_done_q <= 1'b1;
          else dy_q <= dy_q + 3'd1;
        end else begin
          dx_q <= dx_q + 3'd1;
        end
      end

      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
        if (last) begin
          out_row_q   <= '0;
          out_col_q   <= '0;
          frame_rcv_q <= 1'b0;
        end else if (11'({1'b0, out_col_q}) + 11'd1 >= w) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + ROW_W'(1);
        end else begin
          out_col_q <= out_col_q + COL_W'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[dv/median_window_filter_test.sv]
// Testbench for the streaming per-channel median window filter.
// Depends on mwf_pkg and median_window_filter; it predicts every median from
// its own copy of the line store and checks each result in order.
`timescale 1ns / 100ps
module median_window_filter_test
  import mwf_pkg::*;
();

  localparam logic OP_DRAIN    = 1'b1;
  localparam int   CYCLE_LIMIT = 2000000;
  // Settles any request still in flight once the result queue is empty.
  localparam int   SETTLE      = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_WIDTH;
  logic [12:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_req_t     in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_req_t    out_req;

  median_window_filter DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_req_o(out_req)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the block: register values as written, positions and the store.
  logic [10:0] reg_width  = 11'd1024;
  logic [12:0] reg_height = 13'd768;
  logic [1:0]  reg_radius = 2'd1;
  int          in_col, in_row, out_col, out_row;
  bit          frame_done;
  logic [23:0] pixel_store [STORE_DEPTH];

  out_req_t    median_q [$];
  int          mismatches = 0;
  bit          failed = 1'b0;
  int          cycles = 0;

  // Traffic shaping: percent of cycles the sender idles and the receiver
  // stalls, plus a long receiver hold-off that counts itself down.
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  function automatic int clampi(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] middle_of(logic [7:0] v [WIN_MAX], int n);
    logic [7:0] key;
    int j;
    for (int i = 1; i < n; i++) begin
      key = v[i];
      j = i;
      while (j > 0 && v[j-1] > key) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = key;
    end
    return v[n/2];
  endfunction

  // Advances the shadow by one accepted request and queues any median due.
  task automatic predict_median(input in_req_t req);
    int w, h, r, ny, nx, n, yy, xx;
    bit ready, last;
    logic [23:0] pix;
    logic [7:0] rv [WIN_MAX];
    logic [7:0] gv [WIN_MAX];
    logic [7:0] bv [WIN_MAX];
    out_req_t res;
    w = clampi(int'(reg_width), 1, MAX_WIDTH);
    h = clampi(int'(reg_height), 1, HEIGHT_LIMIT);
    r = clampi(int'(reg_radius), 1, MAX_RADIUS);
    // A pixel offered while the frame is still draining is dropped.
    if (req.operation == OP_PIXEL && !frame_done) begin
      pixel_store[(in_row * w + in_col) % STORE_DEPTH] =
          {req.red_in, req.green_in, req.blue_in};
      if (in_col + 1 >= w) begin
        in_col = 0;
        if (in_row + 1 >= h) begin
          in_row = 0;
          frame_done = 1'b1;
        end else begin
          in_row++;
        end
      end else begin
        in_col++;
      end
    end
    if (frame_done) begin
      ready = 1'b1;
    end else begin
      ny = (out_row + r > h - 1) ? h - 1 : out_row + r;
      nx = (out_col + r > w - 1) ? w - 1 : out_col + r;
      ready = (in_row > ny) || (in_row == ny && in_col > nx);
    end
    if (ready) begin
      n = 0;
      for (int dy = -r; dy <= r; dy++) begin
        yy = clampi(out_row + dy, 0, h - 1);
        for (int dx = -r; dx <= r; dx++) begin
          xx = clampi(out_col + dx, 0, w - 1);
          pix = pixel_store[(yy * w + xx) % STORE_DEPTH];
          rv[n] = pix[23:16];
          gv[n] = pix[15:8];
          bv[n] = pix[7:0];
          n++;
        end
      end
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.red_out    = middle_of(rv, n);
      res.green_out  = middle_of(gv, n);
      res.blue_out   = middle_of(bv, n);
      res.frame_last = last;
      median_q = {median_q, res};
      if (last) begin
        out_row = 0;
        out_col = 0;
        frame_done = 1'b0;
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
  endtask

  // Offers one request, idling first at random; valid is only ever raised
  // here and stays high into the next call, so it never toggles in a step.
  task automatic send_request(input logic op, input bit [23:0] rgb);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req.operation = op;
    {in_req.red_in, in_req.green_in, in_req.blue_in} = rgb;
    do @(posedge clk); while (in_stall);
    predict_median(in_req);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    wait (median_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_WIDTH:  reg_width  = value[10:0];
      CFG_HEIGHT: reg_height = value;
      CFG_RADIUS: reg_radius = value[1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input int w, input int h, input int r);
    go_quiet();
    write_reg(CFG_WIDTH, 13'(w));
    write_reg(CFG_HEIGHT, 13'(h));
    write_reg(CFG_RADIUS, 13'(r));
  endtask

  // Streams one whole frame with random pixels, optionally mixing in drain
  // ticks, then drains; some drain slots carry a pixel that gets dropped.
  task automatic run_frame(input bit noisy);
    int w, h;
    w = clampi(int'(reg_width), 1, MAX_WIDTH);
    h = clampi(int'(reg_height), 1, HEIGHT_LIMIT);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(9) == 0)
        send_request(OP_DRAIN, 24'($urandom));
      send_request(OP_PIXEL, 24'($urandom));
    end
    while (frame_done)
      send_request(($urandom_range(3) == 0) ? OP_PIXEL : OP_DRAIN, 24'($urandom));
  endtask

  // Results are checked in order against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_req);
      end else begin
        if (out_req !== median_q[0]) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("median mismatch: expected r%h g%h b%h last%b, got r%h g%h b%h last%b",
                     median_q[0].red_out, median_q[0].green_out, median_q[0].blue_out,
                     median_q[0].frame_last, out_req.red_out, out_req.green_out,
                     out_req.blue_out, out_req.frame_last);
        end
        void'(median_q.pop_front());
      end
    end
  end

  // Border extremes, an early drain tick, a pixel offered while draining.
  task automatic test_directed();
    set_frame(4, 3, 1);
    send_request(OP_DRAIN, 24'hFFFFFF);
    send_request(OP_PIXEL, 24'h000000);
    send_request(OP_PIXEL, 24'hFFFFFF);
    send_request(OP_DRAIN, 24'h000000);
    send_request(OP_PIXEL, 24'hFF00FF);
    send_request(OP_PIXEL, 24'h00FF00);
    for (int i = 0; i < 8; i++)
      send_request(OP_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
    send_request(OP_PIXEL, 24'h123456);
    while (frame_done) send_request(OP_DRAIN, 24'h0);
  endtask

  // Windows wider than the frame, radius zero and both legal extremes.
  task automatic test_radius();
    set_frame(5, 4, 3);
    run_frame(1'b0);
    set_frame(3, 3, 0);
    run_frame(1'b0);
    set_frame(6, 5, 2);
    run_frame(1'b1);
  endtask

  // Single pixel, zero sizes, a single column and a single row.
  task automatic test_sizes();
    set_frame(1, 1, 1);
    run_frame(1'b0);
    set_frame(0, 0, 2);
    run_frame(1'b0);
    set_frame(1, 40, 3);
    run_frame(1'b0);
    set_frame(60, 1, 3);
    run_frame(1'b0);
  endtask

  task automatic test_random(input int idle, input int stall, input int pixels);
    int sent;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < pixels) begin
      set_frame($urandom_range(16, 1), $urandom_range(8, 1), $urandom_range(3));
      run_frame(1'b1);
      sent += clampi(int'(reg_width), 1, MAX_WIDTH) * clampi(int'(reg_height), 1, HEIGHT_LIMIT);
    end
  endtask

  // Long receiver hold-off while requests keep coming, so the block fills.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    set_frame(8, 6, 1);
    hold_left = 2000;
    run_frame(1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_radius();
    test_sizes();
    test_random(0, 0, 120);
    test_random(87, 0, 120);
    test_random(0, 87, 120);
    test_random(22, 22, 120);
    test_backpressure();
    go_quiet();
    if (!failed && median_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[median_window_filter.f]
rtl/mwf_pkg.sv
rtl/mwf_ram.sv
rtl/mwf_rank.sv
rtl/median_window_filter.sv
dv/median_window_filter_test.sv
